// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pointer motion smoother.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/pms_pkg.sv -----
// ----------------------------------------------------------------------------
// Pointer motion smoother package
// Shared constants, controller states, command and status types.
// ----------------------------------------------------------------------------
package pms_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 10;

    localparam int unsigned IN_W      = 16;   // offset field width
    localparam int unsigned SF_W      = 16;   // smoothing factor, Q0.16
    localparam int unsigned W_W       = 17;   // weight, Q1.16
    localparam int unsigned OUT_W     = 24;   // motion field width
    localparam int unsigned QW        = 24;   // quotient bits produced
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [SF_W-1:0]  SF_RESET = 16'h8000;
    localparam logic [W_W-1:0]   W_ONE    = 17'h10000;
    localparam logic [OUT_W-1:0] OUT_MAX  = 24'h7FFFFF;
    localparam logic [OUT_W-1:0] OUT_MIN  = 24'h800000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP_RD,
        S_TAP_MUL,
        S_TAP_ACC,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic tap_mul;
        logic tap_acc;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic tap_last;
        logic div_last;
    } t_dp_sts;

    // Apply the sign to a quotient magnitude and clamp to the 24-bit range.
    function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [QW-1:0] q);
        logic [OUT_W-1:0] res;
        if (!neg) begin
            res = q[QW-1] ? OUT_MAX : q;
        end else begin
            res = (q[QW-1] && (|q[QW-2:0])) ? OUT_MIN : (~q + 24'd1);
        end
        return res;
    endfunction

endpackage

// ----- sv/pms_datapath.sv -----
// ----------------------------------------------------------------------------
// Pointer motion smoother datapath
// History ring, serial weighted accumulate and restoring divider.
// ----------------------------------------------------------------------------
module pms_datapath #(
    parameter int unsigned HISTORY_DEPTH = pms_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pms_pkg::SF_W-1:0]           i_cfg_wdata,
    input  logic signed [pms_pkg::IN_W-1:0]    i_offset_x,
    input  logic signed [pms_pkg::IN_W-1:0]    i_offset_y,
    input  logic                               i_cursor_shown,
    input  pms_pkg::t_dp_cmd                   i_cmd,
    output pms_pkg::t_dp_sts                   o_sts,
    output logic [pms_pkg::OUT_W-1:0]          o_motion_x,
    output logic [pms_pkg::OUT_W-1:0]          o_motion_y
);

    localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned SUMW_W = pms_pkg::W_W + $clog2(HISTORY_DEPTH);
    localparam int unsigned PROD_W = pms_pkg::IN_W + pms_pkg::W_W + 1;
    localparam int unsigned ACC_W  = PROD_W + $clog2(HISTORY_DEPTH);
    localparam int unsigned NUM_W  = ACC_W + 9;
    localparam int unsigned QW     = pms_pkg::QW;
    localparam int unsigned MEM_W  = 2 * pms_pkg::IN_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    // Control state.
    logic [pms_pkg::SF_W-1:0]  r_sf;
    logic [SLOT_W-1:0]         r_slot;
    logic [HISTORY_DEPTH-1:0]  r_valid;

    // History memory, {y, x} per slot.
    logic [MEM_W-1:0]          mem [HISTORY_DEPTH];
    logic [MEM_W-1:0]          r_rd_data;
    logic                      r_rd_valid;

    logic [SLOT_W-1:0]                  r_addr;
    logic [SLOT_W-1:0]                  r_tap_cnt;
    logic [pms_pkg::W_W-1:0]            r_w;
    logic [SUMW_W-1:0]                  r_sumw;
    logic signed [PROD_W-1:0]           r_px;
    logic signed [PROD_W-1:0]           r_py;
    logic signed [ACC_W-1:0]            r_acc_x;
    logic signed [ACC_W-1:0]            r_acc_y;
    logic                               r_neg_x;
    logic                               r_neg_y;
    logic [SUMW_W-1:0]                  r_rem_x;
    logic [SUMW_W-1:0]                  r_rem_y;
    logic [QW-1:0]                      r_qx;
    logic [QW-1:0]                      r_qy;
    logic [pms_pkg::DIV_CNT_W-1:0]      r_div_cnt;
    logic [pms_pkg::OUT_W-1:0]          r_mx;
    logic [pms_pkg::OUT_W-1:0]          r_my;

    logic [SLOT_W-1:0]                       slot_next;
    logic [SLOT_W-1:0]                       addr_prev;
    logic signed [pms_pkg::IN_W-1:0]         entry_x;
    logic signed [pms_pkg::IN_W-1:0]         entry_y;
    logic signed [PROD_W-1:0]                w_signed;
    logic [pms_pkg::W_W+pms_pkg::SF_W-1:0]   w_prod;
    logic [ACC_W-1:0]                        mag_x;
    logic [ACC_W-1:0]                        mag_y;
    logic [NUM_W-1:0]                        num_x;
    logic [NUM_W-1:0]                        num_y;
    logic [SUMW_W:0]                         part_x;
    logic [SUMW_W:0]                         part_y;
    logic [SUMW_W:0]                         den_ext;
    logic [SUMW_W:0]                         diff_x;
    logic [SUMW_W:0]                         diff_y;
    logic                                    ge_x;
    logic                                    ge_y;

    assign slot_next = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
    assign addr_prev = (r_addr == '0) ? LAST_SLOT : r_addr - SLOT_W'(1);

    // A slot not written since the last clear reads as zero.
    assign entry_x = r_rd_valid ? $signed(r_rd_data[pms_pkg::IN_W-1:0]) : '0;
    assign entry_y = r_rd_valid ? $signed(r_rd_data[MEM_W-1:pms_pkg::IN_W]) : '0;

    assign w_signed = PROD_W'($signed({1'b0, r_w}));
    assign w_prod   = (pms_pkg::W_W + pms_pkg::SF_W)'(r_w)
                    * (pms_pkg::W_W + pms_pkg::SF_W)'(r_sf);

    assign mag_x = r_acc_x[ACC_W-1] ? (~r_acc_x + ACC_W'(1)) : r_acc_x;
    assign mag_y = r_acc_y[ACC_W-1] ? (~r_acc_y + ACC_W'(1)) : r_acc_y;
    assign num_x = NUM_W'({mag_x, 8'h00}) + NUM_W'(r_sumw[SUMW_W-1:1]);
    assign num_y = NUM_W'({mag_y, 8'h00}) + NUM_W'(r_sumw[SUMW_W-1:1]);

    assign den_ext = {1'b0, r_sumw};
    assign part_x  = {r_rem_x, r_qx[QW-1]};
    assign part_y  = {r_rem_y, r_qy[QW-1]};
    assign ge_x    = (part_x >= den_ext);
    assign ge_y    = (part_y >= den_ext);
    assign diff_x  = part_x - den_ext;
    assign diff_y  = part_y - den_ext;

    assign o_sts.tap_last = (r_tap_cnt == LAST_SLOT);
    assign o_sts.div_last = (r_div_cnt == pms_pkg::DIV_CNT_W'(QW - 1));

    assign o_motion_x = r_mx;
    assign o_motion_y = r_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf    <= pms_pkg::SF_RESET;
            r_slot  <= '0;
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sf <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (i_cursor_shown) begin
                    r_valid <= '0;
                end else begin
                    r_slot             <= slot_next;
                    r_valid[slot_next] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_cursor_shown) begin
            mem[slot_next] <= {i_offset_y, i_offset_x};
        end
        r_rd_data  <= mem[r_addr];
        r_rd_valid <= r_valid[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr    <= i_cursor_shown ? r_slot : slot_next;
            r_tap_cnt <= '0;
            r_w       <= pms_pkg::W_ONE;
            r_sumw    <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
        end
        if (i_cmd.tap_mul) begin
            r_px   <= PROD_W'(entry_x) * w_signed;
            r_py   <= PROD_W'(entry_y) * w_signed;
            r_sumw <= r_sumw + SUMW_W'(r_w);
            r_w    <= w_prod[pms_pkg::W_W+pms_pkg::SF_W-1:pms_pkg::SF_W];
            r_addr <= addr_prev;
        end
        if (i_cmd.tap_acc) begin
            r_acc_x   <= r_acc_x + ACC_W'(r_px);
            r_acc_y   <= r_acc_y + ACC_W'(r_py);
            r_tap_cnt <= r_tap_cnt + SLOT_W'(1);
        end
        if (i_cmd.div_init) begin
            r_neg_x   <= r_acc_x[ACC_W-1];
            r_neg_y   <= r_acc_y[ACC_W-1];
            r_rem_x   <= num_x[QW +: SUMW_W];
            r_rem_y   <= num_y[QW +: SUMW_W];
            r_qx      <= num_x[QW-1:0];
            r_qy      <= num_y[QW-1:0];
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem_x   <= ge_x ? diff_x[SUMW_W-1:0] : part_x[SUMW_W-1:0];
            r_rem_y   <= ge_y ? diff_y[SUMW_W-1:0] : part_y[SUMW_W-1:0];
            r_qx      <= {r_qx[QW-2:0], ge_x};
            r_qy      <= {r_qy[QW-2:0], ge_y};
            r_div_cnt <= r_div_cnt + pms_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_mx <= pms_pkg::sat_out(r_neg_x, r_qx);
            r_my <= pms_pkg::sat_out(r_neg_y, r_qy);
        end
    end

endmodule

// ----- sv/pms_ctrl.sv -----
// ----------------------------------------------------------------------------
// Pointer motion smoother controller
// Sequences accept, tap accumulation, division and result hand-off.
// ----------------------------------------------------------------------------
module pms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  pms_pkg::t_dp_sts  i_sts,
    output pms_pkg::t_dp_cmd  o_cmd
);

    pms_pkg::t_state r_state;
    pms_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    // The result register may be refilled once it is empty or being taken.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pms_pkg::S_IDLE: begin
                if (s_axis_tvalid) n_state = pms_pkg::S_TAP_RD;
            end
            pms_pkg::S_TAP_RD:  n_state = pms_pkg::S_TAP_MUL;
            pms_pkg::S_TAP_MUL: n_state = pms_pkg::S_TAP_ACC;
            pms_pkg::S_TAP_ACC: begin
                n_state = i_sts.tap_last ? pms_pkg::S_DIV_INIT : pms_pkg::S_TAP_RD;
            end
            pms_pkg::S_DIV_INIT: n_state = pms_pkg::S_DIV_STEP;
            pms_pkg::S_DIV_STEP: begin
                if (i_sts.div_last) n_state = pms_pkg::S_DONE;
            end
            pms_pkg::S_DONE: begin
                if (out_free) n_state = pms_pkg::S_IDLE;
            end
            default: n_state = pms_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            pms_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.accept  = s_axis_tvalid;
            end
            pms_pkg::S_TAP_RD:   o_cmd = '0;
            pms_pkg::S_TAP_MUL:  o_cmd.tap_mul  = 1'b1;
            pms_pkg::S_TAP_ACC:  o_cmd.tap_acc  = 1'b1;
            pms_pkg::S_DIV_INIT: o_cmd.div_init = 1'b1;
            pms_pkg::S_DIV_STEP: o_cmd.div_step = 1'b1;
            pms_pkg::S_DONE:     o_cmd.load_out = out_free;
            default:             o_cmd = '0;
        endcase
    end

    always_comb begin
        priority if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pms_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- sv/pointer_motion_smoother_top.sv -----
// ----------------------------------------------------------------------------
// Pointer motion smoother
// Geometric weighted moving average of recent pointer offsets.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream carries one pointer tick: the offset pair
// in s_axis_tdata and the cursor-shown flag in s_axis_tuser. A tick with the
// cursor hidden pushes its offsets into a ring of HISTORY_DEPTH entries; a
// tick with the cursor shown empties the ring. Every tick yields exactly one
// transfer on the master stream with the smoothed motion in both axes, as
// signed values with 8 fraction bits, saturated to 24 bits.
// The smoothing factor (unsigned Q0.16) is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce; it resets to one half. The ring is
// read one entry at a time through one memory port and one multiplier per
// axis, in read, multiply and accumulate steps, and a restoring divider
// then produces one quotient bit a cycle.
// One tick is worked on at a time: a new tick is taken once the previous
// result has been loaded into the output register, even if that result is
// still waiting. If the receiver stalls, the finished next result waits
// inside the block until the output register frees. Synchronous reset
// empties the ring, resets the factor and drops any pending result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pointer_motion_smoother_top #(
    parameter int unsigned HISTORY_DEPTH = pms_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: smoothing factor, unsigned Q0.16.
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // Pointer ticks in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] offset_x, [31:16] offset_y
    input  logic        s_axis_tuser,   // [0] cursor_shown
    // Smoothed motion out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [23:0] motion_x, [47:24] motion_y
);

    pms_pkg::t_dp_cmd dp_cmd;
    pms_pkg::t_dp_sts dp_sts;

    logic [pms_pkg::OUT_W-1:0] motion_x;
    logic [pms_pkg::OUT_W-1:0] motion_y;

    // The controller owns the handshakes and the result-valid flag; all
    // arithmetic and history storage sit in the datapath.
    pms_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd)
    );

    pms_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_offset_x     ($signed(s_axis_tdata[15:0])),
        .i_offset_y     ($signed(s_axis_tdata[31:16])),
        .i_cursor_shown (s_axis_tuser),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_motion_x     (motion_x),
        .o_motion_y     (motion_y)
    );

    assign m_axis_tdata = {motion_y, motion_x};

    // The datapath only starts a tick on a real input transfer.
    `ASSERT_IMPL(a_accept_is_transfer, i_clk, i_rst_n, dp_cmd.accept, s_axis_tvalid && s_axis_tready)
    // Once a tick is taken the block is busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A result is never loaded over one that the receiver has not taken.
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, dp_cmd.load_out, !m_axis_tvalid || m_axis_tready)
    // Loading a result always presents it on the master stream.
    `ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, dp_cmd.load_out, m_axis_tvalid)

endmodule
